// ===== hdl/bset_pkg.sv =====
`default_nettype none

package bset_pkg;

    // Set capacity and derived widths
    localparam int CAPACITY = 128;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 8;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [DATA_W-1:0] data_t;

    localparam cnt_t CAP_CNT = cnt_t'(CAPACITY);

    // Request kinds
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_DUP    = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

endpackage

`default_nettype wire

// ===== hdl/byte_set_insert_remove_lookup.sv =====
// Sequence: latch the request, search one entry a cycle through the single read port of
// the entry store (skipped for an empty set), decide, swap for a removal that hits, then
// wait in the done state until the output register is free. A new request is taken only
// after the previous result has moved into the output register.
// Reset: asynchronous, active low; clears the entry count, sequencer state and output valid.
// Entry store contents are not cleared; entries at or above the count are never used.
`default_nettype none

module byte_set_insert_remove_lookup (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] kind,
    input  wire logic [7:0] value,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            was_member,
    output logic [1:0]      status,
    output logic [7:0]      count
);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SWAP   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] state_reg, state_next;

    // Entry count and per-request control
    bset_pkg::cnt_t  count_reg, count_next;
    bset_pkg::addr_t idx_reg, idx_next;
    bset_pkg::addr_t pos_reg, pos_next;
    logic            found_reg, found_next;

    // Latched request payload
    logic [1:0]      kind_reg, kind_next;
    bset_pkg::data_t value_reg, value_next;

    // Result staged before the output register
    logic [1:0]      res_status_reg, res_status_next;
    bset_pkg::cnt_t  res_count_reg, res_count_next;

    // Output register
    logic            out_valid_reg, out_valid_next;
    logic            out_member_reg, out_member_next;
    logic [1:0]      out_status_reg, out_status_next;
    bset_pkg::cnt_t  out_count_reg, out_count_next;

    // Entry store port
    logic            ram_we;
    bset_pkg::addr_t ram_waddr;
    bset_pkg::data_t ram_wdata;
    bset_pkg::addr_t ram_raddr;
    bset_pkg::data_t ram_rdata;

    logic            accept;
    logic            out_free;
    bset_pkg::cnt_t  idx_inc;
    bset_pkg::addr_t last_addr;
    logic [bset_pkg::CNT_W+7:0] count_ext;

    bset_ram #(
        .WIDTH (bset_pkg::DATA_W),
        .DEPTH (bset_pkg::CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Take a new request only between searches; the output register holds the
    // previous result meanwhile.
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign idx_inc   = bset_pkg::cnt_t'(idx_reg) + bset_pkg::cnt_t'(1);
    assign last_addr = bset_pkg::addr_t'(count_reg - bset_pkg::cnt_t'(1));

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        found_next      = found_reg;
        kind_next       = kind_reg;
        value_next      = value_reg;
        res_status_next = res_status_reg;
        res_count_next  = res_count_reg;
        out_member_next = out_member_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_valid_next  = out_valid_reg && out_stall;

        ram_we    = 1'b0;
        ram_waddr = bset_pkg::addr_t'(count_reg);
        ram_wdata = value_reg;
        ram_raddr = '0;

        case (state_reg)
            S_IDLE:
            begin
                // Read entry 0 ahead of the first compare
                ram_raddr = '0;
                if (accept)
                begin
                    kind_next  = kind;
                    value_next = value;
                    idx_next   = '0;
                    found_next = 1'b0;
                    if (count_reg == '0)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end

            S_SEARCH:
            begin
                // Compare one entry a cycle and prefetch the next
                ram_raddr = bset_pkg::addr_t'(idx_inc);
                if (ram_rdata == value_reg)
                begin
                    found_next = 1'b1;
                    pos_next   = idx_reg;
                    state_next = S_DECIDE;
                end
                else if (idx_inc == count_reg)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    idx_next = bset_pkg::addr_t'(idx_inc);
                end
            end

            S_DECIDE:
            begin
                // Fetch the last entry in case a removal needs it
                ram_raddr      = last_addr;
                state_next     = S_DONE;
                res_count_next = count_reg;
                case (kind_reg)
                    bset_pkg::KIND_INSERT:
                    begin
                        if (count_reg >= bset_pkg::CAP_CNT)
                        begin
                            res_status_next = bset_pkg::ST_FULL;
                        end
                        else if (found_reg)
                        begin
                            res_status_next = bset_pkg::ST_DUP;
                        end
                        else
                        begin
                            // Append at the end
                            ram_we          = 1'b1;
                            ram_waddr       = bset_pkg::addr_t'(count_reg);
                            ram_wdata       = value_reg;
                            count_next      = count_reg + bset_pkg::cnt_t'(1);
                            res_count_next  = count_next;
                            res_status_next = bset_pkg::ST_DONE;
                        end
                    end
                    bset_pkg::KIND_REMOVE:
                    begin
                        if (found_reg)
                        begin
                            count_next      = count_reg - bset_pkg::cnt_t'(1);
                            res_count_next  = count_next;
                            res_status_next = bset_pkg::ST_DONE;
                            state_next      = S_SWAP;
                        end
                        else
                        begin
                            res_status_next = bset_pkg::ST_ABSENT;
                        end
                    end
                    default:
                    begin
                        // Query, and the unused code behaves as one
                        res_status_next = found_reg ? bset_pkg::ST_DONE : bset_pkg::ST_ABSENT;
                    end
                endcase
            end

            S_SWAP:
            begin
                // Move the last entry into the freed slot
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = ram_rdata;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // Hold here until the output register is free
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_member_next = found_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = res_count_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        found_reg      <= found_next;
        kind_reg       <= kind_next;
        value_reg      <= value_next;
        res_status_reg <= res_status_next;
        res_count_reg  <= res_count_next;
        out_member_reg <= out_member_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    // Count shows the low eight bits
    assign count_ext  = {8'd0, out_count_reg};
    assign count      = count_ext[7:0];
    assign out_valid  = out_valid_reg;
    assign was_member = out_member_reg;
    assign status     = out_status_reg;

endmodule

`default_nettype wire

// ===== hdl/bset_ram.sv =====
`default_nettype none

module bset_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== bench/tb_byte_set_insert_remove_lookup.sv =====
`timescale 1ns / 100ps

module tb_byte_set_insert_remove_lookup;

    import bset_pkg::*;

    // Kind code 3 has no name in the package; the block decodes it as a query.
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 9;
    localparam int ITEM_TOTAL     = 1150;
    localparam int WATCHDOG_LIMIT = 4000;
    // Longest search plus swap write, taken twice over.
    localparam int DRAIN_CYCLES   = 2 * (CAPACITY + 6);
    localparam int DIRECTED_ROWS  = 22;

    // One reply of the block, one field per output port.
    typedef struct packed {
        logic       was_member;
        logic [1:0] status;
        logic [7:0] count;
    } set_reply_t;

    // Directed row: request plus, where it is obvious, the reply typed in by hand.
    typedef struct {
        logic [1:0] kind;
        logic [7:0] value;
        bit         typed;
        logic       was_member;
        logic [1:0] status;
        logic [7:0] count;
    } directed_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] kind = KIND_QUERY;
    logic [7:0] value = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       was_member;
    logic [1:0] status;
    logic [7:0] count;

    // Shadow copy of the set, advanced at each accepted request.
    logic [7:0] shadow_entries [0:CAPACITY-1];
    int         shadow_size = 0;

    set_reply_t expected_replies [$];
    int         mismatches = 0;
    int         requests_sent = 0;
    int         burst_left = 0;
    int         idle_cycles = 0;

    // Receiver stall pattern state.
    int         stall_mode = 0;
    int         stall_run = 0;

    // Walk through the empty set, both value extremes, duplicate and absent
    // cases, the spare kind code, and removal of both a first and a last entry.
    directed_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        '{KIND_QUERY,  8'h00, 1'b1, 1'b0, ST_ABSENT, 8'd0},
        '{KIND_REMOVE, 8'hFF, 1'b1, 1'b0, ST_ABSENT, 8'd0},
        '{KIND_INSERT, 8'h00, 1'b1, 1'b0, ST_DONE,   8'd1},
        '{KIND_INSERT, 8'hFF, 1'b1, 1'b0, ST_DONE,   8'd2},
        '{KIND_INSERT, 8'hFF, 1'b1, 1'b1, ST_DUP,    8'd2},
        '{KIND_QUERY,  8'hFF, 1'b1, 1'b1, ST_DONE,   8'd2},
        '{KIND_QUERY,  8'h00, 1'b1, 1'b1, ST_DONE,   8'd2},
        '{KIND_SPARE,  8'h00, 1'b1, 1'b1, ST_DONE,   8'd2},
        '{KIND_SPARE,  8'h07, 1'b1, 1'b0, ST_ABSENT, 8'd2},
        '{KIND_INSERT, 8'h55, 1'b1, 1'b0, ST_DONE,   8'd3},
        '{KIND_INSERT, 8'hAA, 1'b1, 1'b0, ST_DONE,   8'd4},
        '{KIND_REMOVE, 8'h00, 1'b1, 1'b1, ST_DONE,   8'd3},
        '{KIND_QUERY,  8'hAA, 1'b0, 1'b0, ST_DONE,   8'd0},
        '{KIND_QUERY,  8'h00, 1'b1, 1'b0, ST_ABSENT, 8'd3},
        '{KIND_REMOVE, 8'hAA, 1'b1, 1'b1, ST_DONE,   8'd2},
        '{KIND_REMOVE, 8'hAA, 1'b1, 1'b0, ST_ABSENT, 8'd2},
        '{KIND_REMOVE, 8'hFF, 1'b1, 1'b1, ST_DONE,   8'd1},
        '{KIND_REMOVE, 8'h55, 1'b1, 1'b1, ST_DONE,   8'd0},
        '{KIND_QUERY,  8'h55, 1'b1, 1'b0, ST_ABSENT, 8'd0},
        '{KIND_INSERT, 8'h80, 1'b1, 1'b0, ST_DONE,   8'd1},
        '{KIND_INSERT, 8'h01, 1'b0, 1'b0, ST_DONE,   8'd0},
        '{KIND_REMOVE, 8'h80, 1'b0, 1'b0, ST_DONE,   8'd0}
    };

    byte_set_insert_remove_lookup dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .was_member (was_member),
        .status     (status),
        .count      (count)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Apply one request to the shadow set and return the reply it should give.
    // The search covers occupied slots only; a full-set insert is refused
    // before the duplicate check, yet still reports membership.
    function automatic set_reply_t apply_set_request(logic [1:0] k, logic [7:0] v);
        int         slot;
        set_reply_t reply;
        slot = -1;
        for (int i = 0; i < shadow_size; i++)
        begin
            if (slot < 0 && shadow_entries[i] == v)
                slot = i;
        end
        reply.was_member = (slot >= 0);
        case (k)
            KIND_INSERT:
            begin
                if (shadow_size >= CAPACITY)
                    reply.status = ST_FULL;
                else if (slot >= 0)
                    reply.status = ST_DUP;
                else
                begin
                    shadow_entries[shadow_size] = v;
                    shadow_size++;
                    reply.status = ST_DONE;
                end
            end
            KIND_REMOVE:
            begin
                if (slot >= 0)
                begin
                    // Move the last entry into the freed slot.
                    shadow_entries[slot] = shadow_entries[shadow_size-1];
                    shadow_size--;
                    reply.status = ST_DONE;
                end
                else
                    reply.status = ST_ABSENT;
            end
            default:
                reply.status = (slot >= 0) ? ST_DONE : ST_ABSENT;
        endcase
        reply.count = 8'(shadow_size);
        return reply;
    endfunction

    function automatic bit in_shadow(logic [7:0] v);
        for (int i = 0; i < shadow_size; i++)
        begin
            if (shadow_entries[i] == v)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Draw a byte not in the set; fall back to any byte once tries run out.
    function automatic logic [7:0] fresh_byte();
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        for (int tries = 0; tries < 64 && in_shadow(v); tries++)
            v = 8'($urandom_range(0, 255));
        return v;
    endfunction

    function automatic logic [7:0] member_byte();
        if (shadow_size == 0)
            return 8'($urandom_range(0, 255));
        return shadow_entries[$urandom_range(0, shadow_size - 1)];
    endfunction

    // Offer one request, hold it until accepted, then log its expected reply.
    // Keep valid high between requests of a burst; drop it only for a gap.
    task automatic send_request(logic [1:0] k, logic [7:0] v, bit typed,
                                set_reply_t typed_reply);
        int         gap;
        set_reply_t predicted;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 160)
                                              : $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        in_valid <= 1'b1;
        kind     <= k;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
        predicted = apply_set_request(k, v);
        expected_replies.push_back(typed ? typed_reply : predicted);
        requests_sent++;
    endtask

    task automatic send_random(logic [1:0] k, logic [7:0] v);
        send_request(k, v, 1'b0, '0);
    endtask

    // Fill the set to capacity with mostly new bytes, then probe the full set.
    task automatic fill_phase();
        int extra;
        while (shadow_size < CAPACITY && requests_sent < ITEM_TOTAL)
        begin
            case ($urandom_range(0, 19))
                0:       send_random(KIND_INSERT, member_byte());
                1:       send_random(KIND_QUERY, 8'($urandom_range(0, 255)));
                default: send_random(KIND_INSERT, fresh_byte());
            endcase
        end
        extra = $urandom_range(4, 10);
        for (int i = 0; i < extra && requests_sent < ITEM_TOTAL; i++)
        begin
            case ($urandom_range(0, 3))
                0:       send_random(KIND_INSERT, member_byte());
                1:       send_random(KIND_QUERY, member_byte());
                default: send_random(KIND_INSERT, fresh_byte());
            endcase
        end
    endtask

    // Shrink the set to a random size, mostly by removing present bytes.
    task automatic drain_phase();
        int target;
        target = $urandom_range(0, shadow_size);
        if ($urandom_range(0, 2) == 0)
            target = 0;
        while (shadow_size > target && requests_sent < ITEM_TOTAL)
        begin
            case ($urandom_range(0, 9))
                0:       send_random(KIND_REMOVE, fresh_byte());
                1:       send_random(KIND_QUERY, member_byte());
                default: send_random(KIND_REMOVE, member_byte());
            endcase
        end
    endtask

    // Unshaped requests: any kind code, any byte.
    task automatic mixed_phase();
        int length;
        length = $urandom_range(10, 40);
        for (int i = 0; i < length && requests_sent < ITEM_TOTAL; i++)
            send_random(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        set_reply_t typed_reply;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            typed_reply.was_member = directed_rows[i].was_member;
            typed_reply.status     = directed_rows[i].status;
            typed_reply.count      = directed_rows[i].count;
            send_request(directed_rows[i].kind, directed_rows[i].value,
                         directed_rows[i].typed, typed_reply);
        end

        while (requests_sent < ITEM_TOTAL)
        begin
            case ($urandom_range(0, 5))
                0, 1:    fill_phase();
                2, 3:    drain_phase();
                default: mixed_phase();
            endcase
        end
        in_valid <= 1'b0;

        // Wait out every pending reply, then watch a while for strays.
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Receiver: switch among stall patterns every so often, including
    // stretches that never stall and stretches that mostly stall.
    always @(posedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(10, 200);
        end
        stall_run--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom_range(0, 1));
            2:       out_stall <= ($urandom_range(0, 7) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Compare each accepted reply with the oldest expectation, field by field.
    always @(posedge clk)
    begin
        set_reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_replies.size() == 0)
            begin
                $error("reply with no request pending: was_member=%0b status=%0d count=%0d",
                       was_member, status, count);
                mismatches++;
            end
            else
            begin
                want = expected_replies.pop_front();
                if (was_member !== want.was_member)
                begin
                    $error("was_member: expected %0b, actual %0b", want.was_member, was_member);
                    mismatches++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    mismatches++;
                end
                if (count !== want.count)
                begin
                    $error("count: expected %0d, actual %0d", want.count, count);
                    mismatches++;
                end
            end
        end
    end

    // Abort when neither channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
